// ----- rtl/core/ocbs_pkg.sv -----
// Shared constants, codes and controller/datapath types for the category bucket store.
`default_nettype none
package ocbs_pkg;

    localparam int MAX_ITEMS      = 64;
    localparam int NUM_CATEGORIES = 4;
    localparam int ADDR_W         = $clog2(MAX_ITEMS);
    localparam int CNT_W          = $clog2(MAX_ITEMS + 1);
    localparam int CAT_W          = 2;
    localparam int ID_W           = 8;
    localparam int CMD_W          = 3;
    localparam int IDX_W          = 6;
    localparam int STAT_W         = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR  = 3'd0,
        CMD_ADD    = 3'd1,
        CMD_REMOVE = 3'd2,
        CMD_CHANGE = 3'd3,
        CMD_FIND   = 3'd4,
        CMD_FIRST  = 3'd5
    } cmd_t;

    localparam logic [STAT_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STAT_W-1:0] ST_BAD_INDEX = 2'd3;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISPATCH,
        S_SHU_RD,
        S_SHU_WR,
        S_INSERT,
        S_MOVE,
        S_SW_RA,
        S_SW_RB,
        S_SW_WA,
        S_SW_WB,
        S_FIND_RD,
        S_FIND_CMP,
        S_FIRST_RES,
        S_REM_RD,
        S_REM_WR,
        S_SHD_RD,
        S_SHD_WR,
        S_RESULT
    } state_t;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_LOAD,
        OP_CLEAR,
        OP_RES_FULL,
        OP_RES_NONE,
        OP_SHU_RD,
        OP_SHU_WR,
        OP_INSERT,
        OP_MOVE_DONE,
        OP_SW_RA,
        OP_SW_RB,
        OP_SW_WA,
        OP_SW_WB,
        OP_FIND_INIT,
        OP_FIND_RD,
        OP_FIND_CMP,
        OP_NOT_FOUND,
        OP_CHG_CHECK,
        OP_FIRST_RD,
        OP_FIRST_RES,
        OP_REM_RD,
        OP_REM_WR,
        OP_SHD_RD,
        OP_SHD_WR,
        OP_REM_DONE,
        OP_PUBLISH
    } op_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             full;
        logic             shift_up_done;
        logic             at_target;
        logic             scan_end;
        logic             match;
        logic             chg_bad;
        logic             store_empty;
        logic             out_free;
    } dp_status_t;

endpackage
`default_nettype wire

// ----- rtl/core/ocbs_datapath.sv -----
// Datapath: item memory, list lengths, walkers, swap holder and result registers.
`default_nettype none
module ocbs_datapath
    import ocbs_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire op_t               op,
    output dp_status_t             stat,
    input  wire logic              cfg_write_en,
    input  wire logic [CAT_W-1:0]  cfg_write_data,
    input  wire logic [CMD_W-1:0]  command,
    input  wire logic [ID_W-1:0]   item_id,
    input  wire logic [CAT_W-1:0]  category,
    input  wire logic [IDX_W-1:0]  index,
    input  wire logic [CAT_W-1:0]  new_category,
    input  wire logic              out_ready,
    output logic                   out_valid,
    output logic                   ok,
    output logic [STAT_W-1:0]      status,
    output logic [CAT_W-1:0]       out_category,
    output logic [IDX_W-1:0]       out_index,
    output logic [ID_W-1:0]        out_item
);

    logic [ID_W-1:0]   mem [MAX_ITEMS];
    logic [ID_W-1:0]   rd_data_reg;

    logic [CNT_W-1:0]  cnt_reg [NUM_CATEGORIES];
    logic [CNT_W-1:0]  cnt_next [NUM_CATEGORIES];
    logic [CAT_W-1:0]  bg_reg, bg_next;
    logic              out_valid_reg, out_valid_next;

    logic [CMD_W-1:0]  cmd_reg, cmd_next;
    logic [ID_W-1:0]   id_reg, id_next;
    logic [CAT_W-1:0]  in_cat_reg, in_cat_next;
    logic [IDX_W-1:0]  in_idx_reg, in_idx_next;
    logic [CAT_W-1:0]  in_ncat_reg, in_ncat_next;
    logic [CAT_W-1:0]  cat_reg, cat_next;
    logic [CAT_W-1:0]  tgt_reg, tgt_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  ptr_reg, ptr_next;
    logic [ID_W-1:0]   tmp_reg, tmp_next;

    logic              res_ok_reg, res_ok_next;
    logic [STAT_W-1:0] res_st_reg, res_st_next;
    logic [CAT_W-1:0]  res_cat_reg, res_cat_next;
    logic [IDX_W-1:0]  res_idx_reg, res_idx_next;
    logic [ID_W-1:0]   res_item_reg, res_item_next;

    logic              o_ok_reg, o_ok_next;
    logic [STAT_W-1:0] o_st_reg, o_st_next;
    logic [CAT_W-1:0]  o_cat_reg, o_cat_next;
    logic [IDX_W-1:0]  o_idx_reg, o_idx_next;
    logic [ID_W-1:0]   o_item_reg, o_item_next;

    logic [CNT_W-1:0]  start_pos [NUM_CATEGORIES+1];
    logic [CNT_W-1:0]  total, cur_cnt, cur_start, cur_last, cur_end;
    logic [CNT_W-1:0]  swap_a, swap_b;
    logic              move_up;
    logic [CAT_W-1:0]  scan_cat;
    logic [CNT_W-1:0]  scan_idx;
    logic [CAT_W-1:0]  first_cat;
    logic              first_found;
    logic [CNT_W-1:0]  first_addr;

    logic              mem_re, mem_we;
    logic [ADDR_W-1:0] mem_raddr, mem_waddr;
    logic [ID_W-1:0]   mem_wdata;

    // List boundaries from the lengths
    always_comb
    begin
        start_pos[0] = '0;
        for (int k = 1; k <= NUM_CATEGORIES; k++)
        begin
            start_pos[k] = start_pos[k-1] + cnt_reg[k-1];
        end
    end

    assign total     = start_pos[NUM_CATEGORIES];
    assign cur_cnt   = cnt_reg[cat_reg];
    assign cur_start = start_pos[cat_reg];
    assign cur_end   = cur_start + cur_cnt;
    assign cur_last  = cur_end - CNT_W'(1);
    assign move_up   = cat_reg < tgt_reg;
    assign swap_a    = cur_start + CNT_W'(idx_reg);
    assign swap_b    = move_up ? cur_last : cur_start;

    // Category that holds the scan position: first list whose end lies beyond it
    always_comb
    begin
        scan_cat = '0;
        for (int k = NUM_CATEGORIES - 1; k >= 0; k--)
        begin
            if (ptr_reg < start_pos[k+1])
            begin
                scan_cat = CAT_W'(k);
            end
        end
        scan_idx = ptr_reg - start_pos[scan_cat];
    end

    // First non-empty category
    always_comb
    begin
        first_cat   = '0;
        first_found = 1'b0;
        for (int k = NUM_CATEGORIES - 1; k >= 0; k--)
        begin
            if (cnt_reg[k] != '0)
            begin
                first_cat   = CAT_W'(k);
                first_found = 1'b1;
            end
        end
        first_addr = start_pos[first_cat] + cnt_reg[first_cat] - CNT_W'(1);
    end

    // Status to the controller
    always_comb
    begin
        stat.cmd           = cmd_reg;
        stat.full          = total >= CNT_W'(MAX_ITEMS);
        stat.shift_up_done = ptr_reg == cur_end;
        stat.at_target     = cat_reg == tgt_reg;
        stat.scan_end      = ptr_reg == total;
        stat.match         = rd_data_reg == id_reg;
        stat.chg_bad       = {1'b0, in_idx_reg} >= cnt_reg[in_cat_reg];
        stat.store_empty   = !first_found;
        stat.out_free      = !out_valid_reg || out_ready;
    end

    // Memory port selection
    always_comb
    begin
        mem_re    = 1'b0;
        mem_we    = 1'b0;
        mem_raddr = '0;
        mem_waddr = '0;
        mem_wdata = rd_data_reg;
        unique case (op)
            OP_SHU_RD:
            begin
                mem_re    = 1'b1;
                mem_raddr = ADDR_W'(ptr_reg - CNT_W'(1));
            end
            OP_SHU_WR:
            begin
                mem_we    = 1'b1;
                mem_waddr = ADDR_W'(ptr_reg);
            end
            OP_INSERT:
            begin
                mem_we    = 1'b1;
                mem_waddr = ADDR_W'(cur_end);
                mem_wdata = id_reg;
            end
            OP_SW_RA:
            begin
                mem_re    = 1'b1;
                mem_raddr = ADDR_W'(swap_a);
            end
            OP_SW_RB:
            begin
                mem_re    = 1'b1;
                mem_raddr = ADDR_W'(swap_b);
            end
            OP_SW_WA:
            begin
                mem_we    = 1'b1;
                mem_waddr = ADDR_W'(swap_a);
            end
            OP_SW_WB:
            begin
                mem_we    = 1'b1;
                mem_waddr = ADDR_W'(swap_b);
                mem_wdata = tmp_reg;
            end
            OP_FIND_RD, OP_SHD_RD:
            begin
                mem_re    = 1'b1;
                mem_raddr = ADDR_W'(ptr_reg);
            end
            OP_FIRST_RD:
            begin
                mem_re    = 1'b1;
                mem_raddr = ADDR_W'(first_addr);
            end
            OP_REM_RD:
            begin
                mem_re    = 1'b1;
                mem_raddr = ADDR_W'(cur_last);
            end
            OP_REM_WR:
            begin
                mem_we    = 1'b1;
                mem_waddr = ADDR_W'(swap_a);
            end
            OP_SHD_WR:
            begin
                mem_we    = 1'b1;
                mem_waddr = ADDR_W'(ptr_reg - CNT_W'(1));
            end
            default:
            begin
                mem_re = 1'b0;
            end
        endcase
    end

    // Item memory with registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    // Next-state of walkers, lengths and results
    always_comb
    begin
        cnt_next      = cnt_reg;
        bg_next       = cfg_write_en ? cfg_write_data : bg_reg;
        cmd_next      = cmd_reg;
        id_next       = id_reg;
        in_cat_next   = in_cat_reg;
        in_idx_next   = in_idx_reg;
        in_ncat_next  = in_ncat_reg;
        cat_next      = cat_reg;
        tgt_next      = tgt_reg;
        idx_next      = idx_reg;
        ptr_next      = ptr_reg;
        tmp_next      = tmp_reg;
        res_ok_next   = res_ok_reg;
        res_st_next   = res_st_reg;
        res_cat_next  = res_cat_reg;
        res_idx_next  = res_idx_reg;
        res_item_next = res_item_reg;
        o_ok_next     = o_ok_reg;
        o_st_next     = o_st_reg;
        o_cat_next    = o_cat_reg;
        o_idx_next    = o_idx_reg;
        o_item_next   = o_item_reg;
        out_valid_next = out_ready ? 1'b0 : out_valid_reg;

        // Default result: all fields zero; the command's own op then sets what it reports
        if (op == OP_CLEAR || op == OP_RES_FULL || op == OP_RES_NONE ||
            op == OP_NOT_FOUND || op == OP_REM_DONE || op == OP_MOVE_DONE ||
            op == OP_FIRST_RES || (op == OP_FIRST_RD && !first_found) ||
            (op == OP_CHG_CHECK && stat.chg_bad) || (op == OP_FIND_CMP && stat.match))
        begin
            res_ok_next   = 1'b0;
            res_st_next   = ST_DONE;
            res_cat_next  = '0;
            res_idx_next  = '0;
            res_item_next = '0;
        end

        unique case (op)
            OP_LOAD:
            begin
                cmd_next     = command;
                id_next      = item_id;
                in_cat_next  = category;
                in_idx_next  = index;
                in_ncat_next = new_category;
                cat_next     = bg_reg;
                tgt_next     = category;
                ptr_next     = total;
            end
            OP_CLEAR:
            begin
                for (int k = 0; k < NUM_CATEGORIES; k++)
                begin
                    cnt_next[k] = '0;
                end
                res_ok_next = 1'b1;
            end
            OP_RES_FULL:
            begin
                res_st_next = ST_FULL;
            end
            OP_SHU_WR:
            begin
                ptr_next = ptr_reg - CNT_W'(1);
            end
            OP_INSERT:
            begin
                cnt_next[cat_reg] = cur_cnt + CNT_W'(1);
                idx_next          = IDX_W'(cur_cnt);
            end
            OP_MOVE_DONE:
            begin
                res_ok_next  = 1'b1;
                res_cat_next = cat_reg;
                res_idx_next = idx_reg;
            end
            OP_SW_RB:
            begin
                tmp_next = rd_data_reg;
            end
            OP_SW_WB:
            begin
                cnt_next[cat_reg] = cur_cnt - CNT_W'(1);
                if (move_up)
                begin
                    cnt_next[cat_reg + CAT_W'(1)] = cnt_reg[cat_reg + CAT_W'(1)] + CNT_W'(1);
                    cat_next = cat_reg + CAT_W'(1);
                    idx_next = '0;
                end
                else
                begin
                    cnt_next[cat_reg - CAT_W'(1)] = cnt_reg[cat_reg - CAT_W'(1)] + CNT_W'(1);
                    cat_next = cat_reg - CAT_W'(1);
                    idx_next = IDX_W'(cnt_reg[cat_reg - CAT_W'(1)]);
                end
            end
            OP_FIND_INIT:
            begin
                ptr_next = '0;
            end
            OP_FIND_CMP:
            begin
                if (stat.match)
                begin
                    cat_next     = scan_cat;
                    idx_next     = IDX_W'(scan_idx);
                    tgt_next     = bg_reg;
                    res_ok_next  = 1'b1;
                    res_cat_next = scan_cat;
                    res_idx_next = IDX_W'(scan_idx);
                end
                else
                begin
                    ptr_next = ptr_reg + CNT_W'(1);
                end
            end
            OP_NOT_FOUND:
            begin
                res_st_next = ST_NOT_FOUND;
            end
            OP_CHG_CHECK:
            begin
                if (stat.chg_bad)
                begin
                    res_st_next = ST_BAD_INDEX;
                end
                cat_next = in_cat_reg;
                idx_next = in_idx_reg;
                tgt_next = in_ncat_reg;
            end
            OP_FIRST_RD:
            begin
                if (!first_found)
                begin
                    res_st_next = ST_NOT_FOUND;
                end
            end
            OP_FIRST_RES:
            begin
                res_ok_next   = 1'b1;
                res_item_next = rd_data_reg;
            end
            OP_REM_WR:
            begin
                ptr_next = cur_end;
            end
            OP_SHD_WR:
            begin
                ptr_next = ptr_reg + CNT_W'(1);
            end
            OP_REM_DONE:
            begin
                cnt_next[cat_reg] = cur_cnt - CNT_W'(1);
                res_ok_next       = 1'b1;
            end
            OP_PUBLISH:
            begin
                o_ok_next      = res_ok_reg;
                o_st_next      = res_st_reg;
                o_cat_next     = res_cat_reg;
                o_idx_next     = res_idx_reg;
                o_item_next    = res_item_reg;
                out_valid_next = 1'b1;
            end
            default:
            begin
                tmp_next = tmp_reg;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_CATEGORIES; k++)
            begin
                cnt_reg[k] <= '0;
            end
            bg_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            bg_reg        <= bg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        id_reg       <= id_next;
        in_cat_reg   <= in_cat_next;
        in_idx_reg   <= in_idx_next;
        in_ncat_reg  <= in_ncat_next;
        cat_reg      <= cat_next;
        tgt_reg      <= tgt_next;
        idx_reg      <= idx_next;
        ptr_reg      <= ptr_next;
        tmp_reg      <= tmp_next;
        res_ok_reg   <= res_ok_next;
        res_st_reg   <= res_st_next;
        res_cat_reg  <= res_cat_next;
        res_idx_reg  <= res_idx_next;
        res_item_reg <= res_item_next;
        o_ok_reg     <= o_ok_next;
        o_st_reg     <= o_st_next;
        o_cat_reg    <= o_cat_next;
        o_idx_reg    <= o_idx_next;
        o_item_reg   <= o_item_next;
    end

    assign out_valid    = out_valid_reg;
    assign ok           = o_ok_reg;
    assign status       = o_st_reg;
    assign out_category = o_cat_reg;
    assign out_index    = o_idx_reg;
    assign out_item     = o_item_reg;

endmodule
`default_nettype wire

// ----- rtl/core/ocbs_controller.sv -----
// Controller: sequences memory shifts, swaps and scans for each command.
`default_nettype none
module ocbs_controller
    import ocbs_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire dp_status_t stat,
    output op_t             op
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                unique case (stat.cmd)
                    CMD_CLEAR:  state_next = S_RESULT;
                    CMD_ADD:    state_next = stat.full ? S_RESULT : S_SHU_RD;
                    CMD_REMOVE, CMD_FIND: state_next = S_FIND_RD;
                    CMD_CHANGE: state_next = stat.chg_bad ? S_RESULT : S_MOVE;
                    CMD_FIRST:  state_next = stat.store_empty ? S_RESULT : S_FIRST_RES;
                    default:    state_next = S_RESULT;
                endcase
            end
            S_SHU_RD:    state_next = stat.shift_up_done ? S_INSERT : S_SHU_WR;
            S_SHU_WR:    state_next = S_SHU_RD;
            S_INSERT:    state_next = S_MOVE;
            S_MOVE:
            begin
                if (!stat.at_target)
                begin
                    state_next = S_SW_RA;
                end
                else if (stat.cmd == CMD_REMOVE)
                begin
                    state_next = S_REM_RD;
                end
                else
                begin
                    state_next = S_RESULT;
                end
            end
            S_SW_RA:     state_next = S_SW_RB;
            S_SW_RB:     state_next = S_SW_WA;
            S_SW_WA:     state_next = S_SW_WB;
            S_SW_WB:     state_next = S_MOVE;
            S_FIND_RD:   state_next = stat.scan_end ? S_RESULT : S_FIND_CMP;
            S_FIND_CMP:
            begin
                if (!stat.match)
                begin
                    state_next = S_FIND_RD;
                end
                else if (stat.cmd == CMD_FIND)
                begin
                    state_next = S_RESULT;
                end
                else
                begin
                    state_next = S_MOVE;
                end
            end
            S_FIRST_RES: state_next = S_RESULT;
            S_REM_RD:    state_next = S_REM_WR;
            S_REM_WR:    state_next = S_SHD_RD;
            S_SHD_RD:    state_next = stat.scan_end ? S_RESULT : S_SHD_WR;
            S_SHD_WR:    state_next = S_SHD_RD;
            S_RESULT:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:     state_next = S_IDLE;
        endcase
    end

    // Datapath commands
    always_comb
    begin
        op       = OP_NOP;
        in_ready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    op = OP_LOAD;
                end
            end
            S_DISPATCH:
            begin
                unique case (stat.cmd)
                    CMD_CLEAR:  op = OP_CLEAR;
                    CMD_ADD:    op = stat.full ? OP_RES_FULL : OP_NOP;
                    CMD_REMOVE, CMD_FIND: op = OP_FIND_INIT;
                    CMD_CHANGE: op = OP_CHG_CHECK;
                    CMD_FIRST:  op = OP_FIRST_RD;
                    default:    op = OP_RES_NONE;
                endcase
            end
            S_SHU_RD:    op = stat.shift_up_done ? OP_INSERT : OP_SHU_RD;
            S_SHU_WR:    op = OP_SHU_WR;
            S_INSERT:    op = OP_NOP;
            S_MOVE:
            begin
                if (!stat.at_target)
                begin
                    op = OP_SW_RA;
                end
                else if (stat.cmd != CMD_REMOVE)
                begin
                    op = OP_MOVE_DONE;
                end
            end
            S_SW_RA:     op = OP_SW_RB;
            S_SW_RB:     op = OP_SW_WA;
            S_SW_WA:     op = OP_SW_WB;
            S_SW_WB:     op = OP_NOP;
            S_FIND_RD:   op = stat.scan_end ? OP_NOT_FOUND : OP_FIND_RD;
            S_FIND_CMP:  op = OP_FIND_CMP;
            S_FIRST_RES: op = OP_FIRST_RES;
            S_REM_RD:    op = OP_REM_RD;
            S_REM_WR:    op = OP_REM_WR;
            S_SHD_RD:    op = stat.scan_end ? OP_REM_DONE : OP_SHD_RD;
            S_SHD_WR:    op = OP_SHD_WR;
            S_RESULT:    op = stat.out_free ? OP_PUBLISH : OP_NOP;
            default:     op = OP_NOP;
        endcase
    end

endmodule
`default_nettype wire

// ----- rtl/core/ordered_category_bucket_store.sv -----
// Top level: ordered per-category item lists with a valid/ready command channel.
//
// Commands enter on in_valid/in_ready with command, item_id, category, index and
// new_category; one result item leaves on out_valid/out_ready with ok, status,
// out_category, out_index and out_item. The background category register is
// written with cfg_write_en/cfg_write_data; the user must write it only while
// the block is idle, which the block does not enforce. One command is worked
// on at a time over a single-port item memory, one read or one write per cycle:
//   clear, bad change, full add, other codes: no memory access
//   first: a read of the last entry of the first non-empty list
//   find: a read and a compare per entry scanned
//   add: a read and write per entry shifted up, then a swap per level moved
//   remove: find, a swap per level, a copy of the last entry, then shift down
// The result sits in an output register; a new command is taken while it waits.
// If the receiver stalls, the next finished result holds until the slot frees.
// Reset empties every list and sets the background category to zero; the item
// memory itself is not cleared.
`default_nettype none
module ordered_category_bucket_store
    import ocbs_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_write_en,
    input  wire logic [CAT_W-1:0]  cfg_write_data,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [CMD_W-1:0]  command,
    input  wire logic [ID_W-1:0]   item_id,
    input  wire logic [CAT_W-1:0]  category,
    input  wire logic [IDX_W-1:0]  index,
    input  wire logic [CAT_W-1:0]  new_category,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic                   ok,
    output logic [STAT_W-1:0]      status,
    output logic [CAT_W-1:0]       out_category,
    output logic [IDX_W-1:0]       out_index,
    output logic [ID_W-1:0]        out_item
);

    op_t        op;
    dp_status_t stat;

    ocbs_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .op       (op)
    );

    ocbs_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .op             (op),
        .stat           (stat),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .command        (command),
        .item_id        (item_id),
        .category       (category),
        .index          (index),
        .new_category   (new_category),
        .out_ready      (out_ready),
        .out_valid      (out_valid),
        .ok             (ok),
        .status         (status),
        .out_category   (out_category),
        .out_index      (out_index),
        .out_item       (out_item)
    );

endmodule
`default_nettype wire
